// File: rtl/core/tnst_pkg.sv
// Shared constants and controller/datapath interface types for the top-N score table.
package tnst_pkg;

  localparam int TABLE_SIZE = 10;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int RANK_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic [DATA_W-1:0] DEFAULT_TAG_RST = DATA_W'(1);

  // controller -> datapath
  typedef struct packed {
    logic             capture;     // latch insert operands, evaluate compares
    logic             commit;      // write insert into table and output word
    logic             load_entry;  // dump one stored entry into output word
    logic             load_empty;  // dump of an empty table
    logic             last;        // final word of a dump
    logic [IDX_W-1:0] idx;         // dump read index
  } tnst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } tnst_stat_t;

endpackage

// File: rtl/core/tnst_dpath.sv
// Datapath: sorted entry cells, insert compare vector, output word register.
module tnst_dpath import tnst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tnst_cmd_t                cmd_i,
  output tnst_stat_t               stat_o,
  input  logic                     cfg_we_i,
  input  logic [DATA_W-1:0]        cfg_wdata_i,
  input  logic signed [DATA_W-1:0] new_score_i,
  input  logic [DATA_W-1:0]        player_tag_i,
  output logic [RANK_W-1:0]        rank_o,
  output logic signed [DATA_W-1:0] entry_score_o,
  output logic [DATA_W-1:0]        entry_tag_o,
  output logic                     entry_valid_o,
  output logic                     dropped_o,
  output logic                     last_o
);

  logic signed [DATA_W-1:0] score_q [TABLE_SIZE];
  logic [DATA_W-1:0]        tag_q   [TABLE_SIZE];
  logic [CNT_W-1:0]         count_q;
  logic [DATA_W-1:0]        def_tag_q;

  logic signed [DATA_W-1:0] ins_score_q;
  logic [DATA_W-1:0]        ins_tag_q;
  logic [TABLE_SIZE-1:0]    ge_d, ge_q;
  logic [TABLE_SIZE-1:0]    hot;
  logic [IDX_W-1:0]         pos;
  logic                     drop;

  logic [RANK_W-1:0]        rank_q;
  logic signed [DATA_W-1:0] out_score_q;
  logic [DATA_W-1:0]        out_tag_q;
  logic                     out_valid_q, dropped_q, last_q;

  // stored entry at or above the new score; the set bits form a prefix
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      ge_d[i] = (CNT_W'(i) < count_q) && (score_q[i] >= new_score_i);
    end
  end

  // first cell below the new score takes it
  always_comb begin
    hot[0] = ~ge_q[0];
    for (int i = 1; i < TABLE_SIZE; i++) begin
      hot[i] = ~ge_q[i] & ge_q[i-1];
    end
    pos = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      pos = pos | (hot[i] ? IDX_W'(i) : '0);
    end
  end

  assign drop = &ge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_tag_q <= DEFAULT_TAG_RST;
    end else if (cfg_we_i) begin
      def_tag_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ins_score_q <= new_score_i;
      ins_tag_q   <= (player_tag_i == '0) ? def_tag_q : player_tag_i;
      ge_q        <= ge_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit && !drop && (count_q < CNT_W'(TABLE_SIZE))) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  // cells below the insert point move down one place
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !drop) begin
      if (hot[0]) begin
        score_q[0] <= ins_score_q;
        tag_q[0]   <= ins_tag_q;
      end
      for (int i = 1; i < TABLE_SIZE; i++) begin
        if (hot[i]) begin
          score_q[i] <= ins_score_q;
          tag_q[i]   <= ins_tag_q;
        end else if (!ge_q[i]) begin
          score_q[i] <= score_q[i-1];
          tag_q[i]   <= tag_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rank_q      <= drop ? RANK_W'(TABLE_SIZE) : RANK_W'(pos);
      out_score_q <= ins_score_q;
      out_tag_q   <= ins_tag_q;
      out_valid_q <= 1'b1;
      dropped_q   <= drop;
      last_q      <= 1'b1;
    end else if (cmd_i.load_entry) begin
      rank_q      <= RANK_W'(cmd_i.idx);
      out_score_q <= score_q[cmd_i.idx];
      out_tag_q   <= tag_q[cmd_i.idx];
      out_valid_q <= 1'b1;
      dropped_q   <= 1'b0;
      last_q      <= cmd_i.last;
    end else if (cmd_i.load_empty) begin
      rank_q      <= '0;
      out_score_q <= '0;
      out_tag_q   <= '0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
      last_q      <= 1'b1;
    end
  end

  assign stat_o.count  = count_q;
  assign rank_o        = rank_q;
  assign entry_score_o = out_score_q;
  assign entry_tag_o   = out_tag_q;
  assign entry_valid_o = out_valid_q;
  assign dropped_o     = dropped_q;
  assign last_o        = last_q;

endmodule

// File: rtl/core/tnst_ctrl.sv
// Controller: sequences inserts and dumps, owns the output word handshake.
module tnst_ctrl import tnst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  tnst_stat_t stat_i,
  output tnst_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DUMP
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             is_last;

  assign slot_free  = ~out_valid_q | out_ready_i;
  assign is_last    = (CNT_W'(idx_q) + CNT_W'(1)) == stat_i.count;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.idx   = idx_q;
    cmd_o.last  = is_last;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_INSERT) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_INSERT;
          end else begin
            idx_d   = '0;
            state_d = ST_DUMP;
          end
        end
      end
      ST_INSERT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (stat_i.count == '0) begin
            cmd_o.load_empty = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            cmd_o.load_entry = 1'b1;
            if (is_last) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/top_n_score_table.sv
// Top level of the top-N score table: controller plus datapath.
//
// Keeps up to TABLE_SIZE (score, tag) entries in descending score order.
// Input channel (in_valid_i/in_ready_o): opcode_i 0 inserts new_score_i with
// player_tag_i (tag 0 stores the default tag), opcode_i 1 dumps the table.
// Output channel (out_valid_o/out_ready_i): one word per insert giving the
// rank reached or dropped_o, or one word per stored entry on a dump with
// last_o on the final one; an empty table dumps one word with entry_valid_o 0.
// Insert: on acceptance the operands and compare vector are registered, and
// the insert state then shifts the cells and loads the output word once the
// output slot is free; no new item is taken until that insert commits.
// Dump: after the start, one output word per cycle while the output slot is
// free, set by the single read port on the entry cells.
// The output word register lets a new item be accepted while the previous
// word waits; while out_ready_i is low the sequencer holds and the input
// side stops taking items once the current one needs the output slot.
// Reset empties the table and sets the default tag to 1. cfg_we_i writes the
// default tag; write it only while the block is idle.
module top_n_score_table import tnst_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [DATA_W-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     opcode_i,
  input  logic signed [DATA_W-1:0] new_score_i,
  input  logic [DATA_W-1:0]        player_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [RANK_W-1:0]        rank_o,
  output logic signed [DATA_W-1:0] entry_score_o,
  output logic [DATA_W-1:0]        entry_tag_o,
  output logic                     entry_valid_o,
  output logic                     dropped_o,
  output logic                     last_o
);

  tnst_cmd_t  cmd;
  tnst_stat_t stat;

  tnst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tnst_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .new_score_i   (new_score_i),
    .player_tag_i  (player_tag_i),
    .rank_o        (rank_o),
    .entry_score_o (entry_score_o),
    .entry_tag_o   (entry_tag_o),
    .entry_valid_o (entry_valid_o),
    .dropped_o     (dropped_o),
    .last_o        (last_o)
  );

endmodule
